// ===== rtl/ocp_pkg.sv =====
// Shared types and constants for the output overcurrent protector.
package ocp_pkg;

    // Field widths fixed by the sample and result formats.
    localparam int CHAN_W    = 6;
    localparam int CURRENT_W = 12;
    localparam int COUNT_W   = 7;
    localparam int FAULT_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    // Fault codes.
    localparam logic [FAULT_W-1:0] FAULT_NONE = 2'h0;
    localparam logic [FAULT_W-1:0] FAULT_OPEN = 2'h1;
    localparam logic [FAULT_W-1:0] FAULT_OVER = 2'h2;

    // Overload counter saturates here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'h7f;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ZERO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ONE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_TWO   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_LEVEL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIP_COUNT  = 3'd5;

    // Input word: one sample for one channel.
    typedef struct packed {
        logic [CHAN_W-1:0]    chan;
        logic                 want_on;
        logic [CURRENT_W-1:0] current;
    } in_word_t;

    // Output word: resulting drive and fault of the channel.
    typedef struct packed {
        logic [CHAN_W-1:0]  out_chan;
        logic               drive_on;
        logic [FAULT_W-1:0] fault;
    } out_word_t;

    // Per-channel state held in memory.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [FAULT_W-1:0] fault;
        logic               drive;
    } chan_state_t;

endpackage

// ===== rtl/ocp_state_mem.sv =====
// Per-channel state memory with valid bits and same-cycle write bypass.
module ocp_state_mem #(
    parameter int DEPTH = 40,
    parameter int IDX_W = 6
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output ocp_pkg::chan_state_t rd_data,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  ocp_pkg::chan_state_t wr_data
);
    import ocp_pkg::*;

    chan_state_t            mem [DEPTH];
    chan_state_t            ram_q_reg;
    logic [DEPTH-1:0]       valid_reg;
    logic                   hit_valid_reg;
    logic                   byp_hit_reg;
    chan_state_t            byp_data_reg;

    // Synchronous memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            ram_q_reg <= mem[rd_addr];
        end
    end

    // Entries never written read as zero; the valid bits stand in for a clear.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            hit_valid_reg <= 1'b0;
            byp_hit_reg   <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                hit_valid_reg <= valid_reg[rd_addr];
                byp_hit_reg   <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Capture the word being written at every read; it is used when the read hits that entry.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            byp_data_reg <= wr_data;
        end
    end

    // Merge bypass, valid bit and memory word.
    always_comb begin
        if (byp_hit_reg) begin
            rd_data = byp_data_reg;
        end else if (hit_valid_reg) begin
            rd_data = ram_q_reg;
        end else begin
            rd_data = '0;
        end
    end

    a_wr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (int'(wr_addr) < DEPTH))
        else $error("state write beyond the last channel");

    a_rd_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en |-> (int'(rd_addr) < DEPTH))
        else $error("state read beyond the last channel");

    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en && (rd_addr == wr_addr)) |=> (rd_data == $past(wr_data)))
        else $error("read of an entry written in the same cycle missed the new word");

endmodule

// ===== rtl/output_overcurrent_protector.sv =====
// Top level of the output overcurrent protector: pipeline, update logic and registers.
//
//   Channel  Direction  Handshake            Word
//   s_       in         s_valid / s_ready    in_word_t  (chan, want_on, current)
//   m_       out        m_valid / m_ready    out_word_t (out_chan, drive_on, fault)
//   cfg_     in         cfg_wr_en            cfg_index, cfg_wdata
//
// One word per cycle is accepted unless the output stalls, and one result per word is
// returned. The state memory is read at the accepting edge, the update runs in the next
// cycle, and the result enters the output register when the update stage advances.
// A word accepted at the edge that writes its channel takes the new state via bypass.
// Reset clears all configuration to defaults and marks all channel state as zero;
// no clearing pass is needed. A stalled output holds the update stage, which then
// holds the input side.
module output_overcurrent_protector #(
    parameter int CHANNELS = 40
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  ocp_pkg::in_word_t             s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output ocp_pkg::out_word_t            m_data,
    input  logic                          cfg_wr_en,
    input  logic [ocp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ocp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import ocp_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CHAN_W:0] CHAN_LIMIT = (CHAN_W + 1)'(CHANNELS);

    // Configuration registers.
    logic [CURRENT_W-1:0] limit_zero_reg;
    logic [CURRENT_W-1:0] limit_one_reg;
    logic [CURRENT_W-1:0] limit_two_reg;
    logic [CURRENT_W-1:0] limit_three_reg;
    logic [CURRENT_W-1:0] open_level_reg;
    logic [COUNT_W-1:0]   trip_count_reg;

    // Update stage and output register.
    logic        st1_valid_reg;
    in_word_t    st1_word_reg;
    logic        st1_in_range_reg;
    logic        m_valid_reg;
    out_word_t   m_data_reg;

    logic        s_accept;
    logic        s_in_range;
    logic        st1_advance;
    chan_state_t cur_state;
    chan_state_t new_state;
    out_word_t   result;
    logic [CURRENT_W-1:0] group_limit;
    logic [IDX_W-1:0]     rd_addr;
    logic [IDX_W-1:0]     wr_addr;
    logic        wr_en;

    // Handshake and stage control.
    assign st1_advance = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready     = !st1_valid_reg || st1_advance;
    assign s_accept    = s_valid && s_ready;
    assign s_in_range  = ({1'b0, s_data.chan} < CHAN_LIMIT);
    assign rd_addr     = s_data.chan[IDX_W-1:0];
    assign wr_addr     = st1_word_reg.chan[IDX_W-1:0];
    assign wr_en       = st1_advance && st1_in_range_reg;
    assign m_valid     = m_valid_reg;
    assign m_data      = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_zero_reg  <= 12'd12;
            limit_one_reg   <= 12'd90;
            limit_two_reg   <= 12'd60;
            limit_three_reg <= 12'd18;
            open_level_reg  <= 12'd6;
            trip_count_reg  <= 7'd100;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LIMIT_ZERO:  limit_zero_reg  <= cfg_wdata;
                CFG_LIMIT_ONE:   limit_one_reg   <= cfg_wdata;
                CFG_LIMIT_TWO:   limit_two_reg   <= cfg_wdata;
                CFG_LIMIT_THREE: limit_three_reg <= cfg_wdata;
                CFG_OPEN_LEVEL:  open_level_reg  <= cfg_wdata;
                CFG_TRIP_COUNT:  trip_count_reg  <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    ocp_state_mem #(
        .DEPTH (CHANNELS),
        .IDX_W (IDX_W)
    ) u_state_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_accept && s_in_range),
        .rd_addr (rd_addr),
        .rd_data (cur_state),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (new_state)
    );

    // Threshold of the channel's group.
    always_comb begin
        if (st1_word_reg.chan == '0) begin
            group_limit = limit_zero_reg;
        end else if (st1_word_reg.chan <= 6'd3) begin
            group_limit = limit_one_reg;
        end else if (st1_word_reg.chan <= 6'd19) begin
            group_limit = limit_two_reg;
        end else begin
            group_limit = limit_three_reg;
        end
    end

    // Channel update: off clears, latched holds, otherwise trip check and counting.
    always_comb begin
        new_state = cur_state;
        if (!st1_word_reg.want_on) begin
            new_state = '0;
        end else if (cur_state.fault != FAULT_OVER) begin
            if (cur_state.count >= trip_count_reg) begin
                new_state.drive = 1'b0;
                new_state.fault = FAULT_OVER;
            end else begin
                new_state.drive = 1'b1;
                new_state.fault = (st1_word_reg.current < open_level_reg) ? FAULT_OPEN
                                                                          : FAULT_NONE;
            end
            if (st1_word_reg.current > group_limit) begin
                if (cur_state.count != COUNT_MAX) begin
                    new_state.count = cur_state.count + 7'd1;
                end
            end else if (cur_state.count != '0) begin
                new_state.count = cur_state.count - 7'd1;
            end
        end
    end

    // Result word; samples for missing channels report off and no fault.
    always_comb begin
        result.out_chan = st1_word_reg.chan;
        result.drive_on = st1_in_range_reg ? new_state.drive : 1'b0;
        result.fault    = st1_in_range_reg ? new_state.fault : FAULT_NONE;
    end

    // Stage valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                st1_valid_reg <= s_accept;
            end
            if (st1_advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_word_reg     <= s_data;
            st1_in_range_reg <= s_in_range;
        end
        if (st1_advance) begin
            m_data_reg <= result;
        end
    end

    a_fault_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.fault == FAULT_NONE || m_data.fault == FAULT_OPEN ||
                     m_data.fault == FAULT_OVER))
        else $error("result carries an undefined fault code");

    a_trip_off: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_data.fault == FAULT_OVER)) |-> !m_data.drive_on)
        else $error("tripped channel still driven");

    a_missing_chan: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && ({1'b0, m_data.out_chan} >= CHAN_LIMIT)) |->
        (!m_data.drive_on && (m_data.fault == FAULT_NONE)))
        else $error("sample for a missing channel gave a drive or fault");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while the update stage was stalled");

endmodule
